>>> src/ssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types, codes and constants for the sensor slot pairing table.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int SLOT_MAX = 5;
    localparam int COLOR_W  = 24;
    localparam int ID_W     = 8;
    localparam int STAT_W   = 8;
    localparam int NUM_W    = 4;

    typedef enum logic [2:0] {
        ST_EMPTY   = 3'd0,
        ST_PAIRING = 3'd1,
        ST_OK      = 3'd2,
        ST_OFFLINE = 3'd3,
        ST_ALARM   = 3'd4
    } slot_st_t;

    typedef enum logic {
        ACT_BUTTON = 1'b0,
        ACT_PACKET = 1'b1
    } act_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EXEC,
        CTL_SEND
    } ctl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the input item
        logic apply;    // update the table and load the result registers
    } ssp_cmd_t;

    localparam logic [COLOR_W-1:0] COLOR_EMPTY   = 24'h000000;
    localparam logic [COLOR_W-1:0] COLOR_PAIRING = 24'h0000FF;
    localparam logic [COLOR_W-1:0] COLOR_OK      = 24'h00FF00;
    localparam logic [COLOR_W-1:0] COLOR_OFFLINE = 24'h00FFFF;
    localparam logic [COLOR_W-1:0] COLOR_ALARM   = 24'hFF0000;

    localparam logic [STAT_W-1:0] ALARM_MASK_RST = 8'h01;

    function automatic logic [COLOR_W-1:0] color_of(input slot_st_t st);
        logic [COLOR_W-1:0] c;
        unique case (st)
            ST_PAIRING: c = COLOR_PAIRING;
            ST_OK:      c = COLOR_OK;
            ST_OFFLINE: c = COLOR_OFFLINE;
            ST_ALARM:   c = COLOR_ALARM;
            default:    c = COLOR_EMPTY;
        endcase
        return c;
    endfunction

endpackage

>>> src/ssp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_ctrl
// Sequencer: takes one event, has the datapath apply it, then offers the
// result until it is transferred.
// ----------------------------------------------------------------------------
module ssp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output ssp_pkg::ssp_cmd_t cmd
);
    import ssp_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.capture = 1'b0;
        cmd.apply   = 1'b0;
        unique case (state_reg)
            CTL_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = CTL_EXEC;
                end
            end
            CTL_EXEC: begin
                cmd.apply  = 1'b1;
                state_next = CTL_SEND;
            end
            CTL_SEND: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = CTL_IDLE;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    a_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##2 m_valid)
        else $error("result not presented two cycles after input transfer");

    a_single_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply |=> !cmd.apply && m_valid)
        else $error("table update not followed by result");

    a_capture_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> (s_valid && s_ready))
        else $error("input captured without a transfer");

endmodule

>>> src/ssp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_datapath
// Slot table, alarm mask, input latch and result registers.
// ----------------------------------------------------------------------------
module ssp_datapath #(
    parameter int SLOT_COUNT = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ssp_pkg::ssp_cmd_t               cmd,
    input  logic                            cfg_wr,
    input  logic [ssp_pkg::STAT_W-1:0]      cfg_data,
    input  logic                            s_action,
    input  logic [ssp_pkg::NUM_W-1:0]       s_slot_number,
    input  logic [ssp_pkg::ID_W-1:0]        s_sensor_id,
    input  logic [ssp_pkg::STAT_W-1:0]      s_packet_status,
    output logic [ssp_pkg::COLOR_W-1:0]     color [ssp_pkg::SLOT_MAX],
    output logic                            alarm_sound,
    output logic                            store_request
);
    import ssp_pkg::*;

    logic [STAT_W-1:0]  alarm_mask_reg;

    act_t               action_reg;
    logic [NUM_W-1:0]   slot_number_reg;
    logic [ID_W-1:0]    sensor_id_reg;
    logic [STAT_W-1:0]  packet_status_reg;

    slot_st_t           st_reg   [SLOT_COUNT];
    slot_st_t           st_next  [SLOT_COUNT];
    logic [ID_W-1:0]    id_reg   [SLOT_COUNT];
    logic [ID_W-1:0]    id_next  [SLOT_COUNT];

    logic [COLOR_W-1:0] color_reg  [SLOT_MAX];
    logic [COLOR_W-1:0] color_next [SLOT_MAX];
    logic               sound_reg;
    logic               sound_next;
    logic               store_reg;
    logic               store_next;
    logic               is_alarm;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_mask_reg <= ALARM_MASK_RST;
        end else if (cfg_wr) begin
            alarm_mask_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg        <= act_t'(s_action);
            slot_number_reg   <= s_slot_number;
            sensor_id_reg     <= s_sensor_id;
            packet_status_reg <= s_packet_status;
        end
    end

    assign is_alarm = |(packet_status_reg & alarm_mask_reg);

    // Event update: button marks a slot pairing; a packet pairs the lowest
    // pairing slot, else updates the first occupied slot with a matching id.
    always_comb begin
        logic paired;
        logic matched;
        paired     = 1'b0;
        matched    = 1'b0;
        store_next = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            st_next[i] = st_reg[i];
            id_next[i] = id_reg[i];
        end
        if (action_reg == ACT_BUTTON) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (slot_number_reg == NUM_W'(i + 1)) begin
                    st_next[i] = ST_PAIRING;
                end
            end
        end else begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (!paired && st_reg[i] == ST_PAIRING) begin
                    st_next[i] = ST_OK;
                    id_next[i] = sensor_id_reg;
                    paired     = 1'b1;
                end
            end
            store_next = paired;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (!paired && !matched && st_reg[i] != ST_EMPTY &&
                    id_reg[i] == sensor_id_reg) begin
                    st_next[i] = is_alarm ? ST_ALARM : ST_OK;
                    matched    = 1'b1;
                end
            end
        end
    end

    always_comb begin
        sound_next = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (st_next[i] == ST_ALARM || st_next[i] == ST_OFFLINE) begin
                sound_next = 1'b1;
            end
        end
    end

    for (genvar g = 0; g < SLOT_MAX; g++) begin : g_color
        if (g < SLOT_COUNT) begin : g_used
            assign color_next[g] = color_of(st_next[g]);
        end else begin : g_unused
            assign color_next[g] = COLOR_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                st_reg[i] <= ST_EMPTY;
                id_reg[i] <= '0;
            end
        end else if (cmd.apply) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                st_reg[i] <= st_next[i];
                id_reg[i] <= id_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            for (int i = 0; i < SLOT_MAX; i++) begin
                color_reg[i] <= color_next[i];
            end
            sound_reg <= sound_next;
            store_reg <= store_next;
        end
    end

    assign color         = color_reg;
    assign alarm_sound   = sound_reg;
    assign store_request = store_reg;

endmodule

>>> src/sensor_slot_pairing_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_slot_pairing_table
// Table of sensor slots with pairing, alarm tracking and per-slot colors.
// ----------------------------------------------------------------------------
// Each event (button press or radio packet) yields exactly one result: the
// color of every slot and the buzzer and store flags after the event. An
// event is taken in the controller's IDLE state, applied to the table in
// EXEC, and its result is offered in SEND; the block takes a new event in
// the cycle after the result transfer, so it takes no new event while a
// result is pending, in the controller's three-state sequence. The
// alarm mask can be written at any time on the cfg channel, which is always
// ready; it resets to 1. Slot colors at or above SLOT_COUNT read as zero.
module sensor_slot_pairing_table #(
    parameter int SLOT_COUNT = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssp_pkg::STAT_W-1:0]      cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [ssp_pkg::NUM_W-1:0]       s_slot_number,
    input  logic [ssp_pkg::ID_W-1:0]        s_sensor_id,
    input  logic [ssp_pkg::STAT_W-1:0]      s_packet_status,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ssp_pkg::COLOR_W-1:0]     m_slot0_color,
    output logic [ssp_pkg::COLOR_W-1:0]     m_slot1_color,
    output logic [ssp_pkg::COLOR_W-1:0]     m_slot2_color,
    output logic [ssp_pkg::COLOR_W-1:0]     m_slot3_color,
    output logic [ssp_pkg::COLOR_W-1:0]     m_slot4_color,
    output logic                            m_alarm_sound,
    output logic                            m_store_request
);
    import ssp_pkg::*;

    ssp_cmd_t           cmd;
    logic [COLOR_W-1:0] color [SLOT_MAX];

    assign cfg_ready = 1'b1;

    ssp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    ssp_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg_wr          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .s_action        (s_action),
        .s_slot_number   (s_slot_number),
        .s_sensor_id     (s_sensor_id),
        .s_packet_status (s_packet_status),
        .color           (color),
        .alarm_sound     (m_alarm_sound),
        .store_request   (m_store_request)
    );

    assign m_slot0_color = color[0];
    assign m_slot1_color = color[1];
    assign m_slot2_color = color[2];
    assign m_slot3_color = color[3];
    assign m_slot4_color = color[4];

endmodule
